### design/nested_region_profile_table_top_defines.svh
// Assertion macros for the nested region profile table.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef NESTED_REGION_PROFILE_TABLE_TOP_DEFINES_SVH
`define NESTED_REGION_PROFILE_TABLE_TOP_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define NRPT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define NRPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/nrpt_pkg.sv
// Shared types and codes for the nested region profile table.
// No dependencies.
package nrpt_pkg;

  localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ENTER = 2'd0,
    KIND_LEAVE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        act;     // perform the enter/leave update this cycle
    logic        leave;   // 1 leave, 0 enter
    logic        append;  // selected slot is a new entry
    logic [15:0] key;
    logic [63:0] t;
  } cmd_t;

  // Readout passed from cell to cell.
  typedef struct packed {
    logic [15:0] key;
    logic [63:0] calls;
    logic [63:0] total;
    logic [15:0] depth;
  } rd_t;

endpackage

### design/nrpt_cell.sv
// One table slot: key, call count, total, start time and depth.
// Depends on nrpt_pkg; chained through the readout bus.
module nrpt_cell
  import nrpt_pkg::*;
#(
  parameter int KW = 16
) (
  input  logic        clk,
  input  cmd_t        cmd,
  input  logic        used,
  input  logic        sel,
  input  rd_t         chain_in,
  output rd_t         chain_out,
  output logic        hit
);

  logic [KW-1:0] key;
  logic [63:0]   calls;
  logic [63:0]   total;
  logic [63:0]   start;
  logic [15:0]   depth;

  logic [KW-1:0] key_next;
  logic [63:0]   calls_next;
  logic [63:0]   total_next;
  logic [63:0]   start_next;
  logic [15:0]   depth_next;
  logic [63:0]   b_calls;
  logic [63:0]   b_total;
  logic [63:0]   b_start;
  logic [15:0]   b_depth;

  assign hit = used && (key == cmd.key[KW-1:0]);

  always_comb begin
    b_calls = cmd.append ? 64'd0 : calls;
    b_total = cmd.append ? 64'd0 : total;
    b_start = cmd.append ? 64'd0 : start;
    b_depth = cmd.append ? 16'd0 : depth;
    key_next   = cmd.append ? cmd.key[KW-1:0] : key;
    calls_next = calls;
    total_next = total;
    start_next = start;
    depth_next = depth;
    if (cmd.act) begin
      if (!cmd.leave) begin
        calls_next = b_calls + 64'd1;
        total_next = b_total;
        start_next = b_start;
        depth_next = b_depth;
        if (b_depth != DEPTH_MAX) begin
          depth_next = b_depth + 16'd1;
          if (b_depth == 16'd0) start_next = cmd.t;
        end
      end else if (depth != 16'd0) begin
        depth_next = depth - 16'd1;
        if (depth == 16'd1 && cmd.t >= start) total_next = total + (cmd.t - start);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.act) begin
      key   <= key_next;
      calls <= calls_next;
      total <= total_next;
      start <= start_next;
      depth <= depth_next;
    end
  end

  always_comb begin
    chain_out = chain_in;
    if (sel) begin
      chain_out.key   = chain_in.key | 16'(key_next);
      chain_out.calls = chain_in.calls | calls_next;
      chain_out.total = chain_in.total | total_next;
      chain_out.depth = chain_in.depth | depth_next;
    end
  end

endmodule

### design/nested_region_profile_table_top.sv
// Nested region profile table: controller plus a row of slot cells.
// Depends on nrpt_pkg, nrpt_cell and nested_region_profile_table_top_defines.svh.
// Flow: an input is captured in idle, matched in the look state, then applied and its result
// registered in exec, which waits while a stalled result is pending; in_stall holds new inputs until idle.
// Reset: synchronous; profiling disabled and table empty, no clearing pass.
`include "nested_region_profile_table_top_defines.svh"
module nested_region_profile_table_top
  import nrpt_pkg::*;
#(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] region_key,
  input  logic [63:0] timestamp_ns,
  input  logic [5:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  entry_index,
  output logic [15:0] entry_key,
  output logic [63:0] entry_calls,
  output logic [63:0] entry_total_ns,
  output logic [15:0] entry_depth,
  output logic [6:0]  entries_used
);

  localparam int KW = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t        state;
  logic          enabled;
  logic [CW-1:0] used_count;
  logic [1:0]    kind_q;
  logic [15:0]   key_q;
  logic [63:0]   t_q;
  logic [5:0]    idx_q;
  logic [IW-1:0] sel_idx;
  logic          sel_vld;
  logic          append;
  logic [2:0]    status_q;
  logic [IW-1:0] sel_idx_next;
  logic          sel_vld_next;
  logic          append_next;
  logic [2:0]    status_next;

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] sel_vec;
  logic [IW-1:0]      hit_idx;
  logic               go;
  cmd_t               cmd;
  rd_t                links [ENTRIES+1];

  assign in_stall = (state != S_IDLE);
  assign go = (state == S_EXEC) && (!out_valid || !out_stall);

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) hit_idx = hit_idx | IW'(i);
    end
  end

  always_comb begin
    sel_idx_next = sel_idx;
    sel_vld_next = 1'b0;
    append_next  = 1'b0;
    status_next  = ST_DONE;
    if (!enabled) begin
      status_next = ST_DISABLED;
    end else begin
      case (kind_q)
        KIND_ENTER: begin
          if (|hit_vec) begin
            sel_idx_next = hit_idx;
            sel_vld_next = 1'b1;
          end else if (32'(used_count) < ENTRIES) begin
            sel_idx_next = IW'(used_count);
            sel_vld_next = 1'b1;
            append_next  = 1'b1;
          end else begin
            status_next = ST_FULL;
          end
        end
        KIND_LEAVE: begin
          if (|hit_vec) begin
            sel_idx_next = hit_idx;
            sel_vld_next = 1'b1;
          end else begin
            status_next = ST_NOT_FOUND;
          end
        end
        KIND_READ: begin
          if (32'(idx_q) < 32'(used_count)) begin
            sel_idx_next = IW'(idx_q);
            sel_vld_next = 1'b1;
          end else begin
            status_next = ST_EMPTY;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd.act    = go && sel_vld && (kind_q == KIND_ENTER || kind_q == KIND_LEAVE);
    cmd.leave  = (kind_q == KIND_LEAVE);
    cmd.append = append;
    cmd.key    = key_q;
    cmd.t      = t_q;
  end

  assign links[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign sel_vec[g] = sel_vld && (sel_idx == IW'(g));
    nrpt_cell #(.KW(KW)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .used      (32'(used_count) > g),
      .sel       (sel_vec[g]),
      .chain_in  (links[g]),
      .chain_out (links[g+1]),
      .hit       (hit_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      enabled    <= 1'b0;
      used_count <= '0;
      sel_vld    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        enabled <= cfg_wdata;
        if (cfg_wdata) used_count <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            key_q  <= region_key & 16'((17'd1 << KW) - 17'd1);
            t_q    <= timestamp_ns;
            idx_q  <= read_index;
            state  <= S_LOOK;
          end
        end
        S_LOOK: begin
          sel_idx  <= sel_idx_next;
          sel_vld  <= sel_vld_next;
          append   <= append_next;
          status_q <= status_next;
          state    <= S_EXEC;
        end
        S_EXEC: begin
          if (go) begin
            if (append && sel_vld) used_count <= used_count + CW'(1);
            out_valid <= 1'b1;
            sel_vld   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (!go && out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status         <= status_q;
      entry_index    <= sel_vld ? 6'(sel_idx) : 6'd0;
      entry_key      <= links[ENTRIES].key;
      entry_calls    <= links[ENTRIES].calls;
      entry_total_ns <= links[ENTRIES].total;
      entry_depth    <= links[ENTRIES].depth;
      entries_used   <= 7'(used_count + CW'(append && sel_vld));
    end
  end

  `NRPT_ASSERT_ALWAYS(a_used_bound, 32'(used_count) <= ENTRIES, "used count above table size")
  `NRPT_ASSERT_ALWAYS(a_key_unique, $onehot0(hit_vec), "region key held by two slots")
  `NRPT_ASSERT_NEXT(a_look_exec, state == S_LOOK, state == S_EXEC, "match step not followed by update")
  `NRPT_ASSERT_NEXT(a_exec_out, go, out_valid && state == S_IDLE, "update without result")

endmodule
